// File: hdl/vpc_pkg.sv
package vpc_pkg;

  localparam int unsigned WINDOW_LEN_DEF = 50;

  localparam int unsigned AXIS_W = 16;
  localparam int unsigned OP_W   = AXIS_W + 1;
  localparam int unsigned SQ_W   = 32;
  localparam int unsigned MAG_W  = 34;
  localparam int unsigned RATE_W = 7;
  localparam int unsigned LVL_W  = 16;

  localparam int unsigned IN_DATA_W  = 48;
  localparam int unsigned OUT_DATA_W = 48;
  localparam int unsigned OUT_PAD_W  = OUT_DATA_W - MAG_W - RATE_W;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] REG_BASE_X        = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_Y        = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_BASE_Z        = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_SUSPECT_LEVEL = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] REG_FISH_LEVEL    = 3'd4;
  localparam logic [CFG_ADDR_W-1:0] REG_BLOWUP_LEVEL  = 3'd5;
  localparam logic [CFG_ADDR_W-1:0] REG_NOISE_LEVEL   = 3'd6;
  localparam logic [CFG_ADDR_W-1:0] REG_NOISE_RATE    = 3'd7;

  localparam logic [LVL_W-1:0]  SUSPECT_LEVEL_RST = 16'd4915;
  localparam logic [LVL_W-1:0]  FISH_LEVEL_RST    = 16'd19661;
  localparam logic [LVL_W-1:0]  BLOWUP_LEVEL_RST  = 16'd57344;
  localparam logic [LVL_W-1:0]  NOISE_LEVEL_RST   = 16'd32768;
  localparam logic [RATE_W-1:0] NOISE_RATE_RST    = 7'd20;
  localparam logic [RATE_W-1:0] RATE_MAX          = 7'd127;

  localparam logic [1:0] SGN_NONE = 2'd0;
  localparam logic [1:0] SGN_POS  = 2'd1;
  localparam logic [1:0] SGN_NEG  = 2'd2;

  localparam logic [2:0] STEP_DX    = 3'd0;
  localparam logic [2:0] STEP_DY    = 3'd1;
  localparam logic [2:0] STEP_DZ    = 3'd2;
  localparam logic [2:0] STEP_NOISE = 3'd3;
  localparam logic [2:0] STEP_BLOW  = 3'd4;
  localparam logic [2:0] STEP_FISH  = 3'd5;
  localparam logic [2:0] STEP_SUSP  = 3'd6;
  localparam logic [2:0] STEP_FLUSH = 3'd7;

  typedef enum logic [1:0] {
    ROD_IDLE    = 2'd0,
    ROD_SUSPECT = 2'd1,
    ROD_FISH    = 2'd2,
    ROD_BLOWUP  = 2'd3
  } rod_state_e;

  typedef struct packed {
    logic             flag;
    logic [MAG_W-1:0] mag;
  } entry_t;

  typedef struct packed {
    logic [SQ_W-1:0] noise_sq;
    logic [SQ_W-1:0] blowup_sq;
    logic [SQ_W-1:0] fish_sq;
    logic [SQ_W-1:0] suspect_sq;
  } thr_t;

endpackage

// File: hdl/vpc_squarer.sv
module vpc_squarer (
  input  logic                             clk_i,
  input  logic signed [vpc_pkg::OP_W-1:0] op_i,
  output logic [vpc_pkg::SQ_W-1:0]        sq_o
);

  logic signed [2*vpc_pkg::OP_W-1:0] prod;
  logic [vpc_pkg::SQ_W-1:0]          sq_q;

  assign prod = op_i * op_i;

  // |op| <= 65535, so the square always fits in 32 bits
  always_ff @(posedge clk_i) begin
    sq_q <= prod[vpc_pkg::SQ_W-1:0];
  end

  assign sq_o = sq_q;

endmodule

// File: hdl/vpc_window_ram.sv
module vpc_window_ram #(
  parameter int unsigned DEPTH = vpc_pkg::WINDOW_LEN_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic            clk_i,
  input  logic            we_i,
  input  logic [AW-1:0]   waddr_i,
  input  vpc_pkg::entry_t wdata_i,
  input  logic [AW-1:0]   raddr_i,
  output vpc_pkg::entry_t rdata_o
);

  vpc_pkg::entry_t mem [DEPTH];
  vpc_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/vpc_classify.sv
module vpc_classify (
  input  logic [vpc_pkg::MAG_W-1:0]  peak_i,
  input  logic [vpc_pkg::RATE_W-1:0] rate_i,
  input  logic [vpc_pkg::RATE_W-1:0] noise_rate_i,
  input  vpc_pkg::thr_t              thr_i,
  output vpc_pkg::rod_state_e        rod_state_o
);

  logic [vpc_pkg::MAG_W-1:0] noise_sq;
  logic [vpc_pkg::MAG_W-1:0] blowup_sq;
  logic [vpc_pkg::MAG_W-1:0] fish_sq;
  logic [vpc_pkg::MAG_W-1:0] suspect_sq;

  assign noise_sq   = vpc_pkg::MAG_W'(thr_i.noise_sq);
  assign blowup_sq  = vpc_pkg::MAG_W'(thr_i.blowup_sq);
  assign fish_sq    = vpc_pkg::MAG_W'(thr_i.fish_sq);
  assign suspect_sq = vpc_pkg::MAG_W'(thr_i.suspect_sq);

  always_comb begin
    priority if (rate_i > noise_rate_i && peak_i < noise_sq) begin
      rod_state_o = vpc_pkg::ROD_IDLE;
    end else if (peak_i > blowup_sq) begin
      rod_state_o = vpc_pkg::ROD_BLOWUP;
    end else if (peak_i > fish_sq) begin
      rod_state_o = vpc_pkg::ROD_FISH;
    end else if (peak_i > suspect_sq) begin
      rod_state_o = vpc_pkg::ROD_SUSPECT;
    end else begin
      rod_state_o = vpc_pkg::ROD_IDLE;
    end
  end

endmodule

// File: hdl/vibration_peak_classifier.sv
// Vibration peak classifier.
// Input stream: one three-axis sample per transfer on s_axis. Output stream:
// one result per sample on m_axis once WINDOW_LEN samples have been seen;
// earlier samples only fill the window and give no transfer.
// Per sample the block takes the baselines off, squares the three deviations
// and the four thresholds on one shared squarer, writes magnitude and X
// crossing flag into the window RAM, then, once the window has filled,
// scans the whole window through the RAM read port, one entry a cycle,
// and classifies.
// s_axis_tready is high only between samples. A finished result sits in an
// output register, so the next sample is taken while it waits; if m_axis is
// still stalled when that sample is classified, the block holds there.
// Reset clears the fill count, the write slot, the X sign history and the
// output valid and loads the register defaults; the RAM is not cleared, as
// no entry is read before the window has filled.
// Config writes (cfg_we_i) are taken at any time and must come while idle.
module vibration_peak_classifier #(
  parameter int unsigned WINDOW_LEN = vpc_pkg::WINDOW_LEN_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // accel_x, accel_y, accel_z
  input  logic [vpc_pkg::IN_DATA_W-1:0]       s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // peak_mag_sq, crossing_rate, zero pad
  output logic [vpc_pkg::OUT_DATA_W-1:0]      m_axis_tdata,
  // rod_state
  output logic [1:0]                          m_axis_tuser,
  input  logic                                cfg_we_i,
  input  logic [vpc_pkg::CFG_ADDR_W-1:0]      cfg_addr_i,
  input  logic [vpc_pkg::CFG_DATA_W-1:0]      cfg_wdata_i
);

  localparam int unsigned AW  = $clog2(WINDOW_LEN);
  localparam int unsigned FW  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned CW  = $clog2(WINDOW_LEN);
  localparam int unsigned RFW = CW + 8;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_CALC  = 6'b000010,
    ST_WRITE = 6'b000100,
    ST_SCAN  = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_CLASS = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration
  logic [vpc_pkg::LVL_W-1:0]  base_x_q, base_y_q, base_z_q;
  logic [vpc_pkg::LVL_W-1:0]  suspect_level_q, fish_level_q, blowup_level_q, noise_level_q;
  logic [vpc_pkg::RATE_W-1:0] noise_rate_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_x_q        <= '0;
      base_y_q        <= '0;
      base_z_q        <= '0;
      suspect_level_q <= vpc_pkg::SUSPECT_LEVEL_RST;
      fish_level_q    <= vpc_pkg::FISH_LEVEL_RST;
      blowup_level_q  <= vpc_pkg::BLOWUP_LEVEL_RST;
      noise_level_q   <= vpc_pkg::NOISE_LEVEL_RST;
      noise_rate_q    <= vpc_pkg::NOISE_RATE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        vpc_pkg::REG_BASE_X:        base_x_q        <= cfg_wdata_i;
        vpc_pkg::REG_BASE_Y:        base_y_q        <= cfg_wdata_i;
        vpc_pkg::REG_BASE_Z:        base_z_q        <= cfg_wdata_i;
        vpc_pkg::REG_SUSPECT_LEVEL: suspect_level_q <= cfg_wdata_i;
        vpc_pkg::REG_FISH_LEVEL:    fish_level_q    <= cfg_wdata_i;
        vpc_pkg::REG_BLOWUP_LEVEL:  blowup_level_q  <= cfg_wdata_i;
        vpc_pkg::REG_NOISE_LEVEL:   noise_level_q   <= cfg_wdata_i;
        vpc_pkg::REG_NOISE_RATE:    noise_rate_q    <= cfg_wdata_i[vpc_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  logic                              in_fire;
  logic signed [vpc_pkg::OP_W-1:0]   dx_c, dy_c, dz_c;
  logic signed [vpc_pkg::OP_W-1:0]   dx_q, dy_q, dz_q;
  logic [1:0]                        sign_c;
  logic [1:0]                        prev_sign_q;
  logic                              flag_q;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  assign dx_c = {s_axis_tdata[15], s_axis_tdata[15:0]}  - {base_x_q[15], base_x_q};
  assign dy_c = {s_axis_tdata[31], s_axis_tdata[31:16]} - {base_y_q[15], base_y_q};
  assign dz_c = {s_axis_tdata[47], s_axis_tdata[47:32]} - {base_z_q[15], base_z_q};

  always_comb begin
    if (dx_c[vpc_pkg::OP_W-1]) begin
      sign_c = vpc_pkg::SGN_NEG;
    end else if (dx_c != '0) begin
      sign_c = vpc_pkg::SGN_POS;
    end else begin
      sign_c = vpc_pkg::SGN_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_sign_q <= vpc_pkg::SGN_NONE;
    end else if (in_fire) begin
      prev_sign_q <= sign_c;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      dx_q   <= dx_c;
      dy_q   <= dy_c;
      dz_q   <= dz_c;
      flag_q <= (sign_c == vpc_pkg::SGN_POS && prev_sign_q == vpc_pkg::SGN_NEG) ||
                (sign_c == vpc_pkg::SGN_NEG && prev_sign_q == vpc_pkg::SGN_POS);
    end
  end

  // shared squarer: deviations, then thresholds; the product is registered
  logic [2:0]                      step_q;
  logic signed [vpc_pkg::OP_W-1:0] sq_op;
  logic [vpc_pkg::SQ_W-1:0]        sq_res;
  logic [vpc_pkg::MAG_W-1:0]       mag_q;
  vpc_pkg::thr_t                   thr_q;

  always_comb begin
    unique case (step_q)
      vpc_pkg::STEP_DX:    sq_op = dx_q;
      vpc_pkg::STEP_DY:    sq_op = dy_q;
      vpc_pkg::STEP_DZ:    sq_op = dz_q;
      vpc_pkg::STEP_NOISE: sq_op = {1'b0, noise_level_q};
      vpc_pkg::STEP_BLOW:  sq_op = {1'b0, blowup_level_q};
      vpc_pkg::STEP_FISH:  sq_op = {1'b0, fish_level_q};
      vpc_pkg::STEP_SUSP:  sq_op = {1'b0, suspect_level_q};
      default:             sq_op = '0;
    endcase
  end

  vpc_squarer u_squarer (
    .clk_i (clk_i),
    .op_i  (sq_op),
    .sq_o  (sq_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= vpc_pkg::STEP_DX;
    end else if (in_fire) begin
      step_q <= vpc_pkg::STEP_DX;
    end else if (state_q == ST_CALC) begin
      step_q <= step_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_CALC) begin
      unique case (step_q)
        vpc_pkg::STEP_DY:    mag_q <= vpc_pkg::MAG_W'(sq_res);
        vpc_pkg::STEP_DZ:    mag_q <= mag_q + vpc_pkg::MAG_W'(sq_res);
        vpc_pkg::STEP_NOISE: mag_q <= mag_q + vpc_pkg::MAG_W'(sq_res);
        vpc_pkg::STEP_BLOW:  thr_q.noise_sq   <= sq_res;
        vpc_pkg::STEP_FISH:  thr_q.blowup_sq  <= sq_res;
        vpc_pkg::STEP_SUSP:  thr_q.fish_sq    <= sq_res;
        vpc_pkg::STEP_FLUSH: thr_q.suspect_sq <= sq_res;
        default: ;
      endcase
    end
  end

  // window store: write newest, then scan from oldest
  logic [AW-1:0]     slot_q, slot_d;
  logic [FW-1:0]     fill_q;
  logic              full_next;
  logic [AW-1:0]     rd_ptr_q;
  logic [AW-1:0]     scan_cnt_q;
  logic              rd_vld_q, rd_first_q;
  vpc_pkg::entry_t   wr_entry, rd_entry;
  logic [vpc_pkg::MAG_W-1:0] peak_q;
  logic [CW-1:0]     count_q;

  assign slot_d    = (slot_q == AW'(WINDOW_LEN - 1)) ? '0 : slot_q + 1'b1;
  assign full_next = (fill_q == FW'(WINDOW_LEN)) || (fill_q == FW'(WINDOW_LEN - 1));
  assign wr_entry  = '{flag: flag_q, mag: mag_q};

  vpc_window_ram #(
    .DEPTH (WINDOW_LEN),
    .AW    (AW)
  ) u_window_ram (
    .clk_i   (clk_i),
    .we_i    (state_q == ST_WRITE),
    .waddr_i (slot_q),
    .wdata_i (wr_entry),
    .raddr_i (rd_ptr_q),
    .rdata_o (rd_entry)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
      fill_q <= '0;
    end else if (state_q == ST_WRITE) begin
      slot_q <= slot_d;
      if (fill_q != FW'(WINDOW_LEN)) begin
        fill_q <= fill_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      rd_vld_q   <= (state_q == ST_SCAN);
      rd_first_q <= (state_q == ST_SCAN) && (scan_cnt_q == '0);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_WRITE) begin
      rd_ptr_q   <= slot_d;
      scan_cnt_q <= '0;
      peak_q     <= '0;
      count_q    <= '0;
    end else begin
      if (state_q == ST_SCAN) begin
        rd_ptr_q   <= (rd_ptr_q == AW'(WINDOW_LEN - 1)) ? '0 : rd_ptr_q + 1'b1;
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      if (rd_vld_q) begin
        if (rd_entry.mag > peak_q) begin
          peak_q <= rd_entry.mag;
        end
        // the oldest flag looks back past the window
        if (!rd_first_q && rd_entry.flag) begin
          count_q <= count_q + 1'b1;
        end
      end
    end
  end

  // classification and output register
  logic [RFW-1:0]             rate_full;
  logic [vpc_pkg::RATE_W-1:0] rate_c;
  vpc_pkg::rod_state_e        rod_c;
  logic                       out_load;
  logic                       out_vld_q;
  logic [vpc_pkg::MAG_W-1:0]  out_peak_q;
  logic [vpc_pkg::RATE_W-1:0] out_rate_q;
  vpc_pkg::rod_state_e        out_rod_q;

  assign rate_full = RFW'(count_q) << 1;
  assign rate_c    = (rate_full > RFW'(vpc_pkg::RATE_MAX)) ? vpc_pkg::RATE_MAX
                                                          : rate_full[vpc_pkg::RATE_W-1:0];

  vpc_classify u_classify (
    .peak_i       (peak_q),
    .rate_i       (rate_c),
    .noise_rate_i (noise_rate_q),
    .thr_i        (thr_q),
    .rod_state_o  (rod_c)
  );

  assign out_load = (state_q == ST_CLASS) && (!out_vld_q || m_axis_tready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_peak_q <= peak_q;
      out_rate_q <= rate_c;
      out_rod_q  <= rod_c;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {{vpc_pkg::OUT_PAD_W{1'b0}}, out_rate_q, out_peak_q};
  assign m_axis_tuser  = out_rod_q;

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_fire) state_d = ST_CALC;
      ST_CALC:  if (step_q == vpc_pkg::STEP_FLUSH) state_d = ST_WRITE;
      ST_WRITE: state_d = full_next ? ST_SCAN : ST_IDLE;
      ST_SCAN:  if (scan_cnt_q == AW'(WINDOW_LEN - 1)) state_d = ST_DRAIN;
      ST_DRAIN: state_d = ST_CLASS;
      ST_CLASS: if (out_load) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_result_before_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> fill_q == FW'(WINDOW_LEN))
    else $error("result before window filled");

  a_peak_covers_newest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLASS |-> peak_q >= mag_q)
    else $error("peak below newest magnitude");

  a_count_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_CLASS |-> 32'(count_q) < WINDOW_LEN)
    else $error("crossing count exceeds window pairs");

  a_scan_precedes_class : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DRAIN |-> $past(state_q) == ST_SCAN && !rd_first_q)
    else $error("drain without full scan");

endmodule

// File: verif/tb_vibration_peak_classifier.sv
module tb_vibration_peak_classifier;
  import vpc_pkg::*;

  localparam int WIN            = WINDOW_LEN_DEF;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASES         = 7;

  typedef struct packed {
    rod_state_e       state;
    logic [MAG_W-1:0] peak;
    logic [RATE_W-1:0] rate;
  } verdict_t;

  typedef enum int {
    SEG_FULL,
    SEG_QUIET,
    SEG_BUZZ,
    SEG_FLAT_X,
    SEG_STEADY
  } seg_kind_e;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  // accel_x, accel_y, accel_z
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  // peak_mag_sq, crossing_rate, zero pad
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  // rod_state
  logic [1:0]            m_axis_tuser;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  vibration_peak_classifier dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // register mirror
  logic signed [AXIS_W-1:0] m_base_x = '0;
  logic signed [AXIS_W-1:0] m_base_y = '0;
  logic signed [AXIS_W-1:0] m_base_z = '0;
  logic [LVL_W-1:0]  m_suspect_lvl = SUSPECT_LEVEL_RST;
  logic [LVL_W-1:0]  m_fish_lvl    = FISH_LEVEL_RST;
  logic [LVL_W-1:0]  m_blowup_lvl  = BLOWUP_LEVEL_RST;
  logic [LVL_W-1:0]  m_noise_lvl   = NOISE_LEVEL_RST;
  logic [RATE_W-1:0] m_noise_rate  = NOISE_RATE_RST;

  // window mirror
  logic [MAG_W-1:0] win_mag [WIN];
  logic             win_flag [WIN];
  int               wr_slot = 0;
  int               fill_cnt = 0;
  logic [1:0]       prev_sgn = SGN_NONE;

  logic [IN_DATA_W-1:0] sample_q [$];
  verdict_t             expected_verdicts [$];

  int errors = 0;
  int samples_in = 0;
  int results_seen = 0;
  int settings_run = 0;
  int idle_cycles = 0;
  int state_hits [4] = '{0, 0, 0, 0};

  task automatic report_mismatch(input string msg);
    $display("mismatch at result %0d: %s", results_seen, msg);
    errors++;
  endtask

  task automatic classify_sample(input logic [IN_DATA_W-1:0] d);
    logic signed [AXIS_W-1:0] ax, ay, az;
    longint dx, dy, dz;
    logic [1:0] sgn;
    logic flg;
    longint unsigned peak;
    int cnt, idx, rate;
    verdict_t v;
    ax = d[15:0];
    ay = d[31:16];
    az = d[47:32];
    dx = longint'(ax) - longint'(m_base_x);
    dy = longint'(ay) - longint'(m_base_y);
    dz = longint'(az) - longint'(m_base_z);
    sgn = (dx > 0) ? SGN_POS : ((dx < 0) ? SGN_NEG : SGN_NONE);
    flg = (sgn == SGN_POS && prev_sgn == SGN_NEG) || (sgn == SGN_NEG && prev_sgn == SGN_POS);
    prev_sgn = sgn;
    win_mag[wr_slot] = MAG_W'(dx * dx + dy * dy + dz * dz);
    win_flag[wr_slot] = flg;
    wr_slot = (wr_slot + 1) % WIN;
    if (fill_cnt < WIN) fill_cnt++;
    if (fill_cnt < WIN) return;
    peak = 0;
    cnt = 0;
    for (int k = 0; k < WIN; k++) begin
      idx = (wr_slot + k) % WIN;
      if (64'(win_mag[idx]) > peak) peak = 64'(win_mag[idx]);
      if (k > 0 && win_flag[idx]) cnt++;
    end
    rate = (cnt * 2 > 127) ? 127 : cnt * 2;
    if (rate > int'(m_noise_rate) && peak < 64'(m_noise_lvl) * 64'(m_noise_lvl))
      v.state = ROD_IDLE;
    else if (peak > 64'(m_blowup_lvl) * 64'(m_blowup_lvl))
      v.state = ROD_BLOWUP;
    else if (peak > 64'(m_fish_lvl) * 64'(m_fish_lvl))
      v.state = ROD_FISH;
    else if (peak > 64'(m_suspect_lvl) * 64'(m_suspect_lvl))
      v.state = ROD_SUSPECT;
    else
      v.state = ROD_IDLE;
    v.peak = MAG_W'(peak);
    v.rate = RATE_W'(rate);
    expected_verdicts.push_back(v);
  endtask

  // sender: bursts with random gaps
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk_i) begin
    logic nv;
    logic [IN_DATA_W-1:0] nd;
    nv = s_axis_tvalid;
    nd = s_axis_tdata;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        classify_sample(s_axis_tdata);
        samples_in++;
        nv = 1'b0;
      end
      if (!nv) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (sample_q.size() > 0) begin
          nd = sample_q.pop_front();
          nv = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 80);
          end
        end
      end
    end
    s_axis_tvalid <= nv;
    s_axis_tdata <= nd;
  end

  // receiver: stall pattern plus result check
  int stall_left = 0;
  int stall_mode = 0;

  always @(posedge clk_i) begin
    logic nr;
    verdict_t e;
    nr = m_axis_tready;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        results_seen++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected result data %h user %h",
                                    m_axis_tdata, m_axis_tuser));
        end else begin
          e = expected_verdicts.pop_front();
          state_hits[e.state]++;
          if (m_axis_tuser !== e.state)
            report_mismatch($sformatf("rod_state %0d, want %0d", m_axis_tuser, e.state));
          if (m_axis_tdata[MAG_W-1:0] !== e.peak)
            report_mismatch($sformatf("peak_mag_sq %0d, want %0d",
                                      m_axis_tdata[MAG_W-1:0], e.peak));
          if (m_axis_tdata[MAG_W+RATE_W-1:MAG_W] !== e.rate)
            report_mismatch($sformatf("crossing_rate %0d, want %0d",
                                      m_axis_tdata[MAG_W+RATE_W-1:MAG_W], e.rate));
          if (m_axis_tdata[OUT_DATA_W-1:MAG_W+RATE_W] !== '0)
            report_mismatch($sformatf("pad bits %h", m_axis_tdata[OUT_DATA_W-1:MAG_W+RATE_W]));
        end
      end
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        stall_left = (stall_mode == 2) ? $urandom_range(1, 150) : $urandom_range(1, 300);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        0: nr = 1'b1;
        1: nr = 1'($urandom_range(0, 1));
        default: nr = 1'b0;
      endcase
    end
    m_axis_tready <= nr;
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        cfg_we_i || !rst_ni)
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_addr_i <= idx;
    cfg_wdata_i <= val;
    case (idx)
      REG_BASE_X:        m_base_x = val;
      REG_BASE_Y:        m_base_y = val;
      REG_BASE_Z:        m_base_z = val;
      REG_SUSPECT_LEVEL: m_suspect_lvl = val;
      REG_FISH_LEVEL:    m_fish_lvl = val;
      REG_BLOWUP_LEVEL:  m_blowup_lvl = val;
      REG_NOISE_LEVEL:   m_noise_lvl = val;
      REG_NOISE_RATE:    m_noise_rate = val[RATE_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_regs(input logic [15:0] bx, input logic [15:0] by, input logic [15:0] bz,
                          input logic [15:0] sl, input logic [15:0] fl, input logic [15:0] bl,
                          input logic [15:0] nl, input logic [6:0] nrate);
    write_reg(REG_BASE_X, bx);
    write_reg(REG_BASE_Y, by);
    write_reg(REG_BASE_Z, bz);
    write_reg(REG_SUSPECT_LEVEL, sl);
    write_reg(REG_FISH_LEVEL, fl);
    write_reg(REG_BLOWUP_LEVEL, bl);
    write_reg(REG_NOISE_LEVEL, nl);
    write_reg(REG_NOISE_RATE, {9'd0, nrate});
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic int offset_axis(input logic signed [15:0] b, input int off);
    int v;
    v = int'(b) + off;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v;
  endfunction

  function automatic void add_sample(input int x, input int y, input int z);
    sample_q.push_back({z[15:0], y[15:0], x[15:0]});
  endfunction

  function automatic int rand_off(input int amp);
    return int'($urandom_range(0, 2 * amp)) - amp;
  endfunction

  function automatic int pick_amp();
    case ($urandom_range(0, 7))
      0: return 1;
      1: return 8;
      2: return 100;
      3: return 2000;
      4: return 6000;
      5: return 20000;
      6: return 40000;
      default: return 65535;
    endcase
  endfunction

  task automatic add_segment(input seg_kind_e kind, input int len, input int amp);
    int xo;
    int sgn;
    sgn = $urandom_range(0, 1) ? 1 : -1;
    for (int i = 0; i < len; i++) begin
      case (kind)
        SEG_FULL: begin
          xo = $urandom();
          sample_q.push_back(IN_DATA_W'({$urandom(), $urandom()}));
        end
        SEG_BUZZ: begin
          xo = ((i % 2) ? 1 : -1) * int'($urandom_range(1, amp));
          if ($urandom_range(0, 7) == 0) xo = 0;
          add_sample(offset_axis(m_base_x, xo), offset_axis(m_base_y, rand_off(amp)),
                     offset_axis(m_base_z, rand_off(amp)));
        end
        SEG_FLAT_X:
          add_sample(int'(m_base_x), offset_axis(m_base_y, rand_off(amp)),
                     offset_axis(m_base_z, rand_off(amp)));
        SEG_STEADY:
          add_sample(offset_axis(m_base_x, sgn * int'($urandom_range(1, amp))),
                     offset_axis(m_base_y, rand_off(amp)), offset_axis(m_base_z, rand_off(amp)));
        default:
          add_sample(offset_axis(m_base_x, rand_off(amp)), offset_axis(m_base_y, rand_off(amp)),
                     offset_axis(m_base_z, rand_off(amp)));
      endcase
    end
  endtask

  // waits until every sample of the phase is sent and every result is back
  task automatic drain();
    while (sample_q.size() > 0 || s_axis_tvalid) @(posedge clk_i);
    while (expected_verdicts.size() > 0) @(posedge clk_i);
    repeat (WIN + 30) @(posedge clk_i);
  endtask

  initial begin
    int lv [3];
    int t;
    int queued;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: ;
        1: set_regs(16'd0, 16'd0, 16'd0, 16'd50, 16'd1500, 16'd20000, 16'd3000, 7'd10);
        2: set_regs(16'h7FFF, 16'h7FFF, 16'h8000, 16'd0, 16'd0, 16'd0, 16'hFFFF, 7'd0);
        3: set_regs(16'h8000, 16'hFFFF, 16'h0001, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 7'd98);
        default: begin
          for (int i = 0; i < 3; i++) lv[i] = $urandom_range(0, 65535);
          for (int i = 0; i < 2; i++)
            for (int j = 0; j < 2 - i; j++)
              if (lv[j] > lv[j+1]) begin
                t = lv[j];
                lv[j] = lv[j+1];
                lv[j+1] = t;
              end
          set_regs(16'($urandom()), 16'($urandom()), 16'($urandom()),
                   16'(lv[0]), 16'(lv[1]), 16'(lv[2]),
                   16'($urandom_range(0, 65535)), 7'($urandom_range(0, 98)));
        end
      endcase
      if (p == 0) begin
        add_segment(SEG_QUIET, WIN, 100);
        add_sample(-32768, -32768, -32768);
        add_sample(32767, 32767, 32767);
        add_sample(0, 0, 0);
        add_sample(-32768, 32767, 0);
        add_sample(1, 0, 0);
        add_sample(-1, 0, 0);
        add_sample(0, 0, 0);
        add_sample(1, 0, 0);
        add_sample(0, 0, 0);
        add_sample(-1, 0, 0);
        add_sample(32767, 0, 0);
        add_sample(-32768, 0, 0);
        add_sample(0, 32767, -32768);
      end
      if (p == 2) begin
        // largest deviation on every axis, then zero deviation, then mixes of the two
        add_sample(-32768, -32768, 32767);
        add_sample(32767, 32767, -32768);
        add_sample(-32768, 32767, 32767);
        add_sample(32767, -32768, -32768);
      end
      queued = 0;
      while (queued < 110) begin
        t = $urandom_range(5, 80);
        add_segment(seg_kind_e'($urandom_range(0, 4)), t, pick_amp());
        queued += t;
      end
      drain();
      settings_run++;
    end
    if (expected_verdicts.size() > 0)
      report_mismatch($sformatf("%0d results never arrived", expected_verdicts.size()));
    $display("%0d samples over %0d register settings, %0d results checked",
             samples_in, settings_run, results_seen);
    $display("rod states: idle %0d, suspect %0d, fish %0d, blow-up %0d",
             state_hits[ROD_IDLE], state_hits[ROD_SUSPECT], state_hits[ROD_FISH],
             state_hits[ROD_BLOWUP]);
    if (errors == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
